// ----- design/lbp_image_histogram_top_defines.svh -----
// Assertion macros used by the checker file of the LBP histogram block.
`ifndef LBP_IMAGE_HISTOGRAM_TOP_DEFINES_SVH
`define LBP_IMAGE_HISTOGRAM_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp check failed");
// Next-cycle implication checked outside reset.
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp check failed");
`endif

// ----- design/lbp_pkg.sv -----
// Package of the LBP histogram block: constants, types and the code function.
`default_nettype none
package lbp_pkg;
    localparam int unsigned LBP_MAX_WIDTH  = 1024;
    localparam int unsigned LBP_MAX_HEIGHT = 1024;
    localparam int unsigned LBP_BIN_COUNT  = 256;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned COUNT_W = 21;
    localparam int unsigned QDEPTH  = 4;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_DRAIN = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

    typedef enum logic {
        KIND_CODE  = 1'b0,
        KIND_COUNT = 1'b1
    } t_kind;

    // One word handed from the front to the back: up to two codes or a bin read.
    typedef struct packed {
        logic       rd;
        logic [7:0] bin;
        logic       v0;
        logic [7:0] c0;
        logic       e0;
        logic       v1;
        logic [7:0] c1;
        logic       e1;
    } t_job;

    // win: 9 pixels, index row*3+col. Flags give side validity.
    function automatic logic [7:0] lbp_code(input logic [8:0][7:0] win, input int k,
                                            input logic lv, input logic rv,
                                            input logic tv, input logic bv);
        logic [7:0] c;
        logic [7:0] ctr;
        c   = '0;
        ctr = win[3+k];
        if (lv && tv && k >= 1 && win[k-1] >= ctr) c[0] = 1'b1;
        if (tv && win[k] >= ctr) c[1] = 1'b1;
        if (rv && tv && k <= 1 && win[k+1] >= ctr) c[2] = 1'b1;
        if (rv && k <= 1 && win[4+k] >= ctr) c[3] = 1'b1;
        if (rv && bv && k <= 1 && win[7+k] >= ctr) c[4] = 1'b1;
        if (bv && win[6+k] >= ctr) c[5] = 1'b1;
        if (lv && bv && k >= 1 && win[5+k] >= ctr) c[6] = 1'b1;
        if (lv && k >= 1 && win[2+k] >= ctr) c[7] = 1'b1;
        return c;
    endfunction
endpackage
`default_nettype wire

// ----- design/lbp_front.sv -----
// Front part: row stores, 3x3 window and LBP code generation.
`default_nettype none
module lbp_front
    import lbp_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = LBP_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = LBP_MAX_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_operation,
    input  wire logic [7:0]       i_pixel,
    input  wire logic [7:0]       i_bin,
    output logic                  o_job_valid,
    output t_job                  o_job,
    input  wire logic             i_space
);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned AW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] r_wcfg, r_hcfg;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_ecol;
    logic [RW-1:0]    r_erow;

    // Stage 1 registers: memory read in flight.
    logic       r_s1_v, r_s1_pix;
    logic [7:0] r_s1_bot;
    logic       r_s1_tv, r_s1_lv, r_s1_c1, r_s1_last, r_s1_emit;
    logic [7:0] r_top, r_mid;
    logic [7:0] mem_up [MAX_WIDTH];
    logic [7:0] mem_mid[MAX_WIDTH];
    logic [8:0][7:0] r_win;
    logic       r_rd;
    logic [7:0] r_rbin;

    // A column is read and rewritten at the same edge, so the read sees the old row.
    logic       acc, is_pix, is_drn, is_rd, go;
    logic [AW-1:0] addr;

    always_comb begin
        w_eff = (r_wcfg == '0) ? CW'(1)
              : ((32'(r_wcfg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_wcfg));
        h_eff = (r_hcfg == '0) ? RW'(1)
              : ((32'(r_hcfg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(r_hcfg));
    end

    assign o_ready = i_space;
    assign acc     = i_valid && o_ready;
    assign is_pix  = i_operation == OP_PIXEL;
    assign is_drn  = i_operation == OP_DRAIN;
    assign is_rd   = i_operation == OP_READ;
    assign go      = acc && ((is_pix && r_row < h_eff) || (is_drn && r_row == h_eff));
    assign addr    = r_col[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_top <= mem_up[addr];
            r_mid <= mem_mid[addr];
            if (is_pix) begin
                mem_up[addr]  <= mem_mid[addr];
                mem_mid[addr] <= i_pixel;
            end
        end
        r_rbin <= i_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcfg <= CFG_W'(640);
            r_hcfg <= CFG_W'(480);
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_rd   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_wcfg <= i_cfg_data;
            else r_hcfg <= i_cfg_data;
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_rd   <= 1'b0;
        end else begin
            r_s1_v <= go;
            r_rd   <= acc && is_rd;
            if (go) begin
                if (r_col + 1'b1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= (r_row + 1'b1 > h_eff) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_pix  <= is_pix;
            r_s1_bot  <= is_pix ? i_pixel : 8'd0;
            r_s1_tv   <= r_row >= RW'(2);
            r_s1_lv   <= r_col >= CW'(2);
            r_s1_c1   <= r_col >= CW'(1);
            r_s1_last <= r_col == w_eff - 1'b1;
            r_s1_emit <= r_row >= RW'(1);
        end
    end

    // Stage 2: shift the window and form codes.
    logic [8:0][7:0] nwin;
    logic       e_a, e_b, last_a, last_b;
    logic [CW-1:0] ec_a;
    logic [RW-1:0] er_a;
    logic [CW-1:0] n_ecol;
    logic [RW-1:0] n_erow;

    always_comb begin
        nwin    = r_win;
        nwin[0] = r_win[1]; nwin[1] = r_win[2]; nwin[2] = r_top;
        nwin[3] = r_win[4]; nwin[4] = r_win[5]; nwin[5] = r_mid;
        nwin[6] = r_win[7]; nwin[7] = r_win[8]; nwin[8] = r_s1_bot;
        e_a = r_s1_v && r_s1_emit && r_s1_c1;
        e_b = r_s1_v && r_s1_emit && r_s1_last;
        last_a = (r_erow == h_eff - 1'b1) && (r_ecol == w_eff - 1'b1);
        ec_a = r_ecol; er_a = r_erow;
        if (e_a) begin
            if (r_ecol + 1'b1 >= w_eff) begin
                ec_a = '0;
                er_a = (r_erow + 1'b1 >= h_eff) ? '0 : r_erow + 1'b1;
            end else begin
                ec_a = r_ecol + 1'b1;
            end
        end
        last_b = (er_a == h_eff - 1'b1) && (ec_a == w_eff - 1'b1);
        n_ecol = ec_a; n_erow = er_a;
        if (e_b) begin
            if (ec_a + 1'b1 >= w_eff) begin
                n_ecol = '0;
                n_erow = (er_a + 1'b1 >= h_eff) ? '0 : er_a + 1'b1;
            end else begin
                n_ecol = ec_a + 1'b1;
            end
        end
    end

    logic [7:0] code_a, code_b;
    always_comb begin
        code_a = lbp_code(nwin, 1, r_s1_lv, 1'b1, r_s1_tv, r_s1_pix);
        code_b = lbp_code(nwin, 2, r_s1_c1, 1'b0, r_s1_tv, r_s1_pix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_win  <= '0;
            r_ecol <= '0;
            r_erow <= '0;
        end else if (r_s1_v) begin
            r_win  <= nwin;
            r_ecol <= n_ecol;
            r_erow <= n_erow;
        end
    end

    always_comb begin
        o_job_valid = (r_s1_v && (e_a || e_b)) || r_rd;
        o_job.rd  = r_rd;
        o_job.bin = r_rbin;
        o_job.v0  = e_a || e_b;
        o_job.c0  = e_a ? code_a : code_b;
        o_job.e0  = e_a ? last_a : last_b;
        o_job.v1  = e_a && e_b;
        o_job.c1  = code_b;
        o_job.e1  = last_b;
    end
endmodule
`default_nettype wire

// ----- design/lbp_queue.sv -----
// Short job queue between the front and the back parts.
`default_nettype none
module lbp_queue
    import lbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_space,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);
    localparam int unsigned QA = $clog2(QDEPTH);
    t_job r_q[QDEPTH];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;

    // Input is held off once two words wait, leaving room for the word
    // still in the front pipeline.
    assign o_space = r_cnt <= (QA+1)'(QDEPTH - 3);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(i_push) - (QA+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ----- design/lbp_back.sv -----
// Back part: histogram bins and result output for codes and bin reads.
`default_nettype none
module lbp_back
    import lbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  t_job                    i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_kind,
    output logic [7:0]              o_code,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_frame_end
);
    logic [COUNT_W-1:0] r_bins[LBP_BIN_COUNT];
    logic               r_ov;
    logic               r_half;
    logic               r_clearing;
    logic [7:0]         r_clr;
    // Update stage: the bin count is read here and written back on commit.
    logic               r_b_v, r_b_rd, r_b_fe;
    logic [7:0]         r_b_bin;
    logic [COUNT_W-1:0] r_rdata, r_fwd_val;
    logic               r_fwd;
    logic               slot_free, commit, take, use1;
    logic [7:0]         bsel;
    logic [COUNT_W-1:0] cur, n_count;
    logic               wr_en;
    logic [7:0]         wr_addr;
    logic [COUNT_W-1:0] wr_data;

    assign slot_free = !r_ov || i_ready;
    assign commit    = r_b_v && slot_free;
    // A job with two codes takes two output slots; r_half marks the second.
    assign use1    = i_job.v1 && r_half;
    assign take    = i_valid && !r_clearing && (!r_b_v || commit);
    assign o_pop   = take && (i_job.rd || !i_job.v1 || r_half);
    assign bsel    = i_job.rd ? i_job.bin : (use1 ? i_job.c1 : i_job.c0);
    // A bin written back in the cycle it is read again comes from the bypass.
    assign cur     = r_fwd ? r_fwd_val : r_rdata;
    assign n_count = r_b_rd ? '0 : ((cur != {COUNT_W{1'b1}}) ? cur + 1'b1 : cur);
    assign wr_en   = r_clearing || commit;
    assign wr_addr = r_clearing ? r_clr : r_b_bin;
    assign wr_data = r_clearing ? '0 : n_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_bins[wr_addr] <= wr_data;
        if (take) r_rdata <= r_bins[bsel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_b_v      <= 1'b0;
            r_ov       <= 1'b0;
            r_half     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (&r_clr) r_clearing <= 1'b0;
            end
            if (take) r_b_v <= 1'b1;
            else if (commit) r_b_v <= 1'b0;
            if (commit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (take && !i_job.rd && i_job.v1) r_half <= !r_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b_rd    <= i_job.rd;
            r_b_bin   <= bsel;
            r_b_fe    <= i_job.rd ? 1'b0 : (use1 ? i_job.e1 : i_job.e0);
            r_fwd     <= commit && (r_b_bin == bsel);
            r_fwd_val <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_kind      <= r_b_rd ? KIND_COUNT : KIND_CODE;
            o_code      <= r_b_rd ? 8'd0 : r_b_bin;
            o_count     <= r_b_rd ? cur : '0;
            o_frame_end <= r_b_fe;
        end
    end
    assign o_valid = r_ov;
endmodule
`default_nettype wire

// ----- design/lbp_image_histogram_top.sv -----
// Top level of the 3x3 LBP code stream with a 256-bin histogram.
//  channel   direction  handshake           words
//  input     in         i_valid / o_ready   operation, pixel, bin
//  output    out        o_valid / i_ready   kind, code, count, frame_end
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
// One input word a cycle while o_ready is high; results go via stage 1, queue and back part.
// From the second row on, a row's last word yields two codes (width above one), sent as two words.
// Reset is synchronous; row stores hold no reset and are masked at the edges.
// After reset all 256 bins are cleared while words wait in the queue.
// A stalled output holds the back part; once two words wait, input ready falls.
`default_nettype none
module lbp_image_histogram_top
    import lbp_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = LBP_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = LBP_MAX_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_operation,
    input  wire logic [7:0]         i_pixel,
    input  wire logic [7:0]         i_bin,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_kind,
    output logic [7:0]              o_code,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_frame_end
);
    t_job jf, jq;
    logic jf_v, jq_v, space, pop;

    lbp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_operation, .i_pixel, .i_bin,
        .o_job_valid(jf_v), .o_job(jf), .i_space(space)
    );

    lbp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(jf_v), .i_job(jf), .o_space(space),
        .o_valid(jq_v), .o_job(jq), .i_pop(pop)
    );

    lbp_back u_back (
        .i_clk, .i_rst_n, .i_valid(jq_v), .i_job(jq), .o_pop(pop),
        .o_valid, .i_ready, .o_kind, .o_code, .o_count, .o_frame_end
    );
endmodule
`default_nettype wire

// ----- design/lbp_checker.sv -----
// Port-level checker for the LBP histogram block and its bind.
`default_nettype none
`include "lbp_image_histogram_top_defines.svh"
module lbp_checker
    import lbp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic               o_kind,
    input wire logic [7:0]         o_code,
    input wire logic [COUNT_W-1:0] o_count,
    input wire logic               o_frame_end
);
    `LBP_ASSERT_IMPL(a_count_zero, i_clk, i_rst_n, o_valid && o_kind == KIND_CODE, o_count == '0)
    `LBP_ASSERT_IMPL(a_code_zero, i_clk, i_rst_n, o_valid && o_kind == KIND_COUNT, o_code == 8'd0 && !o_frame_end)
    `LBP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_code) && $stable(o_count))
endmodule
bind lbp_image_histogram_top lbp_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_kind, .o_code, .o_count, .o_frame_end
);
`default_nettype wire

// ----- verif/lbp_image_histogram_top_tb.sv -----
// Self-checking testbench for the LBP code stream and its bin-count histogram.
`default_nettype none
module lbp_image_histogram_top_tb;
    import lbp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 24;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         code;
        logic [COUNT_W-1:0] count;
        logic               frame_end;
    } t_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_operation = '0;
    logic [7:0]         i_pixel = '0;
    logic [7:0]         i_bin = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_kind;
    logic [7:0]         o_code;
    logic [COUNT_W-1:0] o_count;
    logic               o_frame_end;

    lbp_image_histogram_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow of the block's state.
    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [7:0]         upper_row [LBP_MAX_WIDTH];
    logic [7:0]         middle_row [LBP_MAX_WIDTH];
    logic [7:0]         window [9];
    int                 in_col, in_row, out_col, out_row;
    logic [COUNT_W-1:0] hist [LBP_BIN_COUNT];
    t_res               pending_results [$];

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    const int NX [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
    const int NY [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};

    function automatic int eff_w();
        return (width_reg < 1) ? 1 : (width_reg > LBP_MAX_WIDTH) ? LBP_MAX_WIDTH : width_reg;
    endfunction

    function automatic int eff_h();
        return (height_reg < 1) ? 1 : (height_reg > LBP_MAX_HEIGHT) ? LBP_MAX_HEIGHT : height_reg;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        foreach (window[i]) window[i] = '0;
    endfunction

    function automatic logic [7:0] pattern_at(int k, bit lv, bit rv, bit tv, bit bv);
        logic [7:0] c;
        bit ok;
        int col, row;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            ok = (NX[i] < 0) ? lv : (NX[i] > 0) ? rv : 1'b1;
            ok = ok && ((NY[i] < 0) ? tv : (NY[i] > 0) ? bv : 1'b1);
            col = k + NX[i];
            row = 1 + NY[i];
            if (ok && col >= 0 && col <= 2 && window[row*3+col] >= window[3+k]) c[i] = 1'b1;
        end
        return c;
    endfunction

    function automatic void push_code(logic [7:0] c);
        t_res r;
        if (hist[c] != COUNT_SAT) hist[c]++;
        r = '{kind: KIND_CODE, code: c, count: '0,
              frame_end: (out_row == eff_h() - 1) && (out_col == eff_w() - 1)};
        pending_results.push_back(r);
        out_col++;
        if (out_col >= eff_w()) begin
            out_col = 0;
            out_row++;
            if (out_row >= eff_h()) out_row = 0;
        end
    endfunction

    function automatic void predict_word(t_op op, logic [7:0] pix, logic [7:0] b);
        int w, h;
        logic [7:0] top, mid, bot;
        w = eff_w();
        h = eff_h();
        if (op == OP_READ) begin
            pending_results.push_back('{kind: KIND_COUNT, code: '0, count: hist[b],
                                        frame_end: 1'b0});
            hist[b] = '0;
            return;
        end
        if (op == OP_NONE) return;
        if (op == OP_PIXEL && in_row >= h) return;
        if (op == OP_DRAIN && in_row != h) return;
        top = upper_row[in_col];
        mid = middle_row[in_col];
        bot = (op == OP_PIXEL) ? pix : 8'd0;
        if (op == OP_PIXEL) begin
            upper_row[in_col] = mid;
            middle_row[in_col] = pix;
        end
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = bot;
        if (in_row >= 1) begin
            if (in_col >= 1)
                push_code(pattern_at(1, in_col >= 2, 1'b1, in_row >= 2, op == OP_PIXEL));
            if (in_col == w - 1)
                push_code(pattern_at(2, in_col >= 1, 1'b0, in_row >= 2, op == OP_PIXEL));
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row > h) in_row = 0;
        end
    endfunction

    // Sender: bursts of back-to-back words separated by random gaps.
    task automatic send_word(t_op op, logic [7:0] pix, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_pixel     <= pix;
        i_bin       <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_word(op, pix, b);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) width_reg = value; else height_reg = value;
        restart_frame();
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_HEIGHT, h[CFG_W-1:0]);
    endtask

    function automatic logic [7:0] rand_pixel(int flavour);
        case (flavour)
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(100, 103));
            default: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Streams one whole frame of the current size followed by its drain ticks.
    task automatic send_frame(int flavour);
        for (int i = 0; i < eff_w() * eff_h(); i++) send_word(OP_PIXEL, rand_pixel(flavour), '0);
        for (int i = 0; i < eff_w(); i++) send_word(OP_DRAIN, '0, '0);
    endtask

    task automatic test_reset_state();
        send_word(OP_READ, '0, 8'd0);
        send_word(OP_READ, '0, 8'd255);
        send_word(OP_NONE, 8'hFF, 8'hFF);
        send_word(OP_DRAIN, '0, '0);
        send_word(OP_PIXEL, 8'd0, '0);
        send_word(OP_PIXEL, 8'd255, '0);
    endtask

    task automatic test_small_frame();
        set_size(3, 3);
        send_word(OP_PIXEL, 8'd10, '0);
        send_word(OP_DRAIN, '0, '0);            // ignored before the last row
        foreach (NX[i]) send_word(OP_PIXEL, (i % 2 == 0) ? 8'd10 : 8'd255, '0);
        send_word(OP_PIXEL, 8'd7, '0);          // ignored while awaiting drain
        send_word(OP_NONE, '0, '0);
        repeat (3) send_word(OP_DRAIN, '0, '0);
        send_word(OP_READ, '0, 8'd0);
        send_word(OP_READ, '0, 8'd0);
        send_word(OP_READ, '0, 8'hFF);
    endtask

    task automatic test_size_extremes();
        set_size(0, 0);
        send_frame(0);
        send_frame(2);
        // Only part of a row is sent at the largest width setting.
        set_size(2047, 1);
        for (int i = 0; i < 40; i++) send_word(OP_PIXEL, rand_pixel(0), '0);
        set_size(2, 1);
        send_frame(2);
    endtask

    task automatic test_random_frames();
        int sent, w, h, n;
        sent = 0;
        while (sent < 520) begin
            if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 6);
                set_size(w, h);
            end
            if ($urandom_range(0, 9) == 0) wait_idle();
            n = eff_w() * eff_h() + eff_w();
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);  // broken-off frame
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 19))
                    0:       send_word(OP_READ, 8'($urandom), 8'($urandom));
                    1:       send_word(OP_NONE, 8'($urandom), 8'($urandom));
                    2:       send_word(OP_DRAIN, 8'($urandom), 8'($urandom));
                    default: send_word((i < eff_w() * eff_h()) ? OP_PIXEL : OP_DRAIN,
                                       rand_pixel($urandom_range(0, 2)), 8'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    task automatic test_bin_sweep();
        for (int b = 0; b < LBP_BIN_COUNT; b++) send_word(OP_READ, 8'($urandom), b[7:0]);
    endtask

    // Receiver stalls follow a mode that steps through four patterns in turn.
    always @(posedge i_clk) begin
        case ((cycles / 300) % 4)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 9) < 7);
            2:       i_ready <= ((cycles % 16) < 3);
            default: i_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_res got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_kind, o_code, o_count, o_frame_end};
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        width_reg  = 11'd640;
        height_reg = 11'd480;
        foreach (hist[i]) hist[i] = '0;
        foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        restart_frame();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_small_frame();
        test_size_extremes();
        test_random_frames();
        test_bin_sweep();
        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
